// ===== hw/rtl/mbe_pkg.sv =====
// Shared constants for the escape-time engine and its divider.
package mbe_pkg;

    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = COORD_BITS - 4;
    localparam int MAX_DIM    = 4096;
    localparam int COUNT_BITS = 16;
    localparam int COL_BITS   = 12;
    localparam int DIM_BITS   = 13;
    localparam int DVS_BITS   = $clog2(MAX_DIM);
    localparam int SPAN_BITS  = COORD_BITS + 1;
    localparam int QUO_BITS   = SPAN_BITS + COL_BITS;
    localparam int STEP_BITS  = $clog2(QUO_BITS + 1);

    typedef enum logic [2:0] {
        REG_X_LEFT   = 3'd0,
        REG_Y_LOW    = 3'd1,
        REG_X_RIGHT  = 3'd2,
        REG_Y_HIGH   = 3'd3,
        REG_WIDTH    = 3'd4,
        REG_HEIGHT   = 3'd5,
        REG_MAX_ITER = 3'd6,
        REG_SPARE    = 3'd7
    } cfg_reg_t;

endpackage

// ===== hw/rtl/mbe_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the pixel mapping.
module mbe_divider import mbe_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [QUO_BITS-1:0] dividend,
    input  logic [DVS_BITS-1:0] divisor,
    output logic                busy,
    output logic                done,
    output logic [QUO_BITS-1:0] quotient
);

    logic [QUO_BITS-1:0]  quo_reg, quo_next;
    logic [DVS_BITS-1:0]  rem_reg, rem_next;
    logic [DVS_BITS-1:0]  dvs_reg, dvs_next;
    logic [STEP_BITS-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DVS_BITS:0]    trial;
    logic [DVS_BITS:0]    trial_diff;
    logic                 fits;

    assign trial      = {rem_reg, quo_reg[QUO_BITS-1]};
    assign trial_diff = trial - {1'b0, dvs_reg};
    assign fits       = trial >= {1'b0, dvs_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = STEP_BITS'(QUO_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[QUO_BITS-2:0], fits};
            rem_next = fits ? trial_diff[DVS_BITS-1:0] : trial[DVS_BITS-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hw/rtl/mandelbrot_escape_time.sv =====
// Escape-time engine: maps a pixel to c and iterates z = z*z + c in Q4.28.
//
// Pixel requests arrive on the s_ channel, one column and row per transfer;
// one escape count leaves on the m_ channel per request, in request order.
// pready is always high. The view corners, image size and iteration limit sit
// in APB registers that the user must write between requests (not enforced).
// A request first maps column and row through one shared 33x33 multiplier
// and a bit-serial divider, which runs the two 45-step divisions.
// Each iteration then uses the same multiplier in order: x*x, y*y, x*y, update.
// s_tready is high only between pixels. The finished count waits in an
// output register; the next request is taken while it waits, and that
// request stalls at its end until the receiver has taken the earlier count.
// Reset restores the default view (-2.0..1.0, -1.0..1.0), 1024x1024 pixels
// and a limit of 255, and drops any pixel in flight.
module mandelbrot_escape_time import mbe_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [11:0] pixel_col, [23:12] pixel_row
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] escape_count
    output logic [15:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PROD_BITS = 2 * COORD_BITS;
    localparam int WIDE_BITS = 48;
    localparam int APB_BITS  = 32;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MULX = 4'd1;
    localparam logic [3:0] ST_STX  = 4'd2;
    localparam logic [3:0] ST_DIVX = 4'd3;
    localparam logic [3:0] ST_MULY = 4'd4;
    localparam logic [3:0] ST_STY  = 4'd5;
    localparam logic [3:0] ST_DIVY = 4'd6;
    localparam logic [3:0] ST_SQX  = 4'd7;
    localparam logic [3:0] ST_SQY  = 4'd8;
    localparam logic [3:0] ST_XY   = 4'd9;
    localparam logic [3:0] ST_TEST = 4'd10;
    localparam logic [3:0] ST_DONE = 4'd11;

    localparam logic signed [COORD_BITS-1:0] COORD_ONE = COORD_BITS'(1) << FRAC_BITS;
    localparam logic signed [COORD_BITS-1:0] X_LEFT_RESET  = -(COORD_ONE + COORD_ONE);
    localparam logic signed [COORD_BITS-1:0] Y_LOW_RESET   = -COORD_ONE;
    localparam logic signed [COORD_BITS-1:0] X_RIGHT_RESET = COORD_ONE;
    localparam logic signed [COORD_BITS-1:0] Y_HIGH_RESET  = COORD_ONE;
    localparam logic [DIM_BITS-1:0]   DIM_RESET  = DIM_BITS'(1024);
    localparam logic [COUNT_BITS-1:0] ITER_RESET = COUNT_BITS'(255);

    localparam logic [PROD_BITS-1:0] ESCAPE_LIMIT = PROD_BITS'(1) << (2 * FRAC_BITS + 2);
    localparam logic signed [WIDE_BITS-1:0] COORD_MAX_W =
        WIDE_BITS'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [WIDE_BITS-1:0] COORD_MIN_W = -COORD_MAX_W - WIDE_BITS'(1);

    function automatic logic signed [COORD_BITS-1:0] sat_coord(
        input logic signed [WIDE_BITS-1:0] v
    );
        logic signed [COORD_BITS-1:0] r;
        if (v > COORD_MAX_W) begin
            r = COORD_MAX_W[COORD_BITS-1:0];
        end else if (v < COORD_MIN_W) begin
            r = COORD_MIN_W[COORD_BITS-1:0];
        end else begin
            r = v[COORD_BITS-1:0];
        end
        return r;
    endfunction

    function automatic logic [DVS_BITS-1:0] dim_divisor(input logic [DIM_BITS-1:0] dim);
        logic [DVS_BITS-1:0] r;
        if (dim > DIM_BITS'(MAX_DIM)) begin
            r = DVS_BITS'(MAX_DIM - 1);
        end else if (dim < DIM_BITS'(2)) begin
            r = DVS_BITS'(1);
        end else begin
            r = DVS_BITS'(dim - 1'b1);
        end
        return r;
    endfunction

    // configuration registers
    logic signed [COORD_BITS-1:0] x_left_reg, x_left_next;
    logic signed [COORD_BITS-1:0] y_low_reg, y_low_next;
    logic signed [COORD_BITS-1:0] x_right_reg, x_right_next;
    logic signed [COORD_BITS-1:0] y_high_reg, y_high_next;
    logic [DIM_BITS-1:0]          width_reg, width_next;
    logic [DIM_BITS-1:0]          height_reg, height_next;
    logic [COUNT_BITS-1:0]        max_iter_reg, max_iter_next;

    // sequencer and datapath
    logic [3:0]                   state_reg, state_next;
    logic [COL_BITS-1:0]          col_reg, col_next;
    logic [COL_BITS-1:0]          row_reg, row_next;
    logic signed [SPAN_BITS-1:0]  span_reg, span_next;
    logic signed [PROD_BITS-1:0]  prod_reg, prod_next;
    logic                         neg_reg, neg_next;
    logic signed [COORD_BITS-1:0] cre_reg, cre_next;
    logic signed [COORD_BITS-1:0] cim_reg, cim_next;
    logic signed [COORD_BITS-1:0] x_reg, x_next;
    logic signed [COORD_BITS-1:0] y_reg, y_next;
    logic signed [PROD_BITS-1:0]  xx_reg, xx_next;
    logic [PROD_BITS-1:0]         sum_reg, sum_next;
    logic signed [PROD_BITS-1:0]  diff_reg, diff_next;
    logic [COUNT_BITS-1:0]        n_reg, n_next;
    logic [COUNT_BITS-1:0]        result_reg, result_next;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [COUNT_BITS-1:0]        m_tdata_reg, m_tdata_next;

    logic                         cfg_wr;
    logic [2:0]                   cfg_idx;
    logic signed [SPAN_BITS-1:0]  mul_a, mul_b;
    logic signed [2*SPAN_BITS-1:0] mul_full;
    logic [QUO_BITS:0]            prod_low;
    logic [QUO_BITS:0]            prod_mag;
    logic                         div_start;
    logic                         div_busy;
    logic                         div_done;
    logic [QUO_BITS-1:0]          div_quo;
    logic [DVS_BITS-1:0]          div_dvs;
    logic signed [WIDE_BITS-1:0]  map_base;
    logic signed [WIDE_BITS-1:0]  map_quo;
    logic signed [WIDE_BITS-1:0]  map_sum;
    logic signed [WIDE_BITS-1:0]  x_sum;
    logic signed [WIDE_BITS-1:0]  y_sum;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];
    assign pready  = 1'b1;

    always_comb begin
        x_left_next   = x_left_reg;
        y_low_next    = y_low_reg;
        x_right_next  = x_right_reg;
        y_high_next   = y_high_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        max_iter_next = max_iter_reg;
        if (cfg_wr) begin
            unique case (cfg_idx)
                REG_X_LEFT:   x_left_next   = pwdata[COORD_BITS-1:0];
                REG_Y_LOW:    y_low_next    = pwdata[COORD_BITS-1:0];
                REG_X_RIGHT:  x_right_next  = pwdata[COORD_BITS-1:0];
                REG_Y_HIGH:   y_high_next   = pwdata[COORD_BITS-1:0];
                REG_WIDTH:    width_next    = pwdata[DIM_BITS-1:0];
                REG_HEIGHT:   height_next   = pwdata[DIM_BITS-1:0];
                REG_MAX_ITER: max_iter_next = pwdata[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_X_LEFT:   prdata = x_left_reg;
            REG_Y_LOW:    prdata = y_low_reg;
            REG_X_RIGHT:  prdata = x_right_reg;
            REG_Y_HIGH:   prdata = y_high_reg;
            REG_WIDTH:    prdata = {{(APB_BITS-DIM_BITS){1'b0}}, width_reg};
            REG_HEIGHT:   prdata = {{(APB_BITS-DIM_BITS){1'b0}}, height_reg};
            REG_MAX_ITER: prdata = {{(APB_BITS-COUNT_BITS){1'b0}}, max_iter_reg};
            default:      prdata = '0;
        endcase
    end

    // shared multiplier, registered into prod_reg every cycle
    always_comb begin
        case (state_reg)
            ST_MULX: begin
                mul_a = signed'(SPAN_BITS'(col_reg));
                mul_b = span_reg;
            end
            ST_MULY: begin
                mul_a = signed'(SPAN_BITS'(row_reg));
                mul_b = span_reg;
            end
            ST_SQX: begin
                mul_a = SPAN_BITS'(x_reg);
                mul_b = SPAN_BITS'(x_reg);
            end
            ST_SQY: begin
                mul_a = SPAN_BITS'(y_reg);
                mul_b = SPAN_BITS'(y_reg);
            end
            default: begin
                mul_a = SPAN_BITS'(x_reg);
                mul_b = SPAN_BITS'(y_reg);
            end
        endcase
    end

    assign mul_full  = mul_a * mul_b;
    assign prod_next = mul_full[PROD_BITS-1:0];

    assign prod_low  = prod_reg[QUO_BITS:0];
    assign prod_mag  = prod_reg[PROD_BITS-1] ? (~prod_low + 1'b1) : prod_low;
    assign div_dvs   = dim_divisor((state_reg == ST_STX) ? width_reg : height_reg);

    assign map_base = (state_reg == ST_DIVX) ? WIDE_BITS'(x_left_reg) : WIDE_BITS'(y_low_reg);
    assign map_quo  = signed'(WIDE_BITS'(div_quo));
    assign map_sum  = neg_reg ? (map_base - map_quo) : (map_base + map_quo);

    assign x_sum = WIDE_BITS'(signed'(diff_reg[PROD_BITS-1:FRAC_BITS])) + WIDE_BITS'(cre_reg);
    assign y_sum = WIDE_BITS'(signed'(prod_reg[PROD_BITS-1:FRAC_BITS-1]))
                 + WIDE_BITS'(cim_reg);

    always_comb begin
        state_next    = state_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        span_next     = span_reg;
        neg_next      = neg_reg;
        cre_next      = cre_reg;
        cim_next      = cim_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        xx_next       = xx_reg;
        sum_next      = sum_reg;
        diff_next     = diff_reg;
        n_next        = n_reg;
        result_next   = result_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        div_start     = 1'b0;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    col_next   = s_tdata[COL_BITS-1:0];
                    row_next   = s_tdata[2*COL_BITS-1:COL_BITS];
                    span_next  = SPAN_BITS'(x_right_reg) - SPAN_BITS'(x_left_reg);
                    state_next = ST_MULX;
                end
            end
            ST_MULX: begin
                span_next  = SPAN_BITS'(y_high_reg) - SPAN_BITS'(y_low_reg);
                state_next = ST_STX;
            end
            ST_STX: begin
                div_start  = 1'b1;
                neg_next   = prod_reg[PROD_BITS-1];
                state_next = ST_DIVX;
            end
            ST_DIVX: begin
                if (div_done) begin
                    cre_next   = sat_coord(map_sum);
                    state_next = ST_MULY;
                end
            end
            ST_MULY: begin
                state_next = ST_STY;
            end
            ST_STY: begin
                div_start  = 1'b1;
                neg_next   = prod_reg[PROD_BITS-1];
                state_next = ST_DIVY;
            end
            ST_DIVY: begin
                if (div_done) begin
                    cim_next   = sat_coord(map_sum);
                    x_next     = '0;
                    y_next     = '0;
                    n_next     = '0;
                    state_next = ST_SQX;
                end
            end
            ST_SQX: begin
                state_next = ST_SQY;
            end
            ST_SQY: begin
                xx_next    = prod_reg;
                state_next = ST_XY;
            end
            ST_XY: begin
                sum_next   = xx_reg + prod_reg;
                diff_next  = xx_reg - prod_reg;
                state_next = ST_TEST;
            end
            ST_TEST: begin
                if (sum_reg >= ESCAPE_LIMIT) begin
                    result_next = n_reg;
                    state_next  = ST_DONE;
                end else if (n_reg >= max_iter_reg) begin
                    result_next = '0;
                    state_next  = ST_DONE;
                end else begin
                    x_next     = sat_coord(x_sum);
                    y_next     = sat_coord(y_sum);
                    n_next     = n_reg + 1'b1;
                    state_next = ST_SQX;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = result_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_left_reg   <= X_LEFT_RESET;
            y_low_reg    <= Y_LOW_RESET;
            x_right_reg  <= X_RIGHT_RESET;
            y_high_reg   <= Y_HIGH_RESET;
            width_reg    <= DIM_RESET;
            height_reg   <= DIM_RESET;
            max_iter_reg <= ITER_RESET;
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            x_left_reg   <= x_left_next;
            y_low_reg    <= y_low_next;
            x_right_reg  <= x_right_next;
            y_high_reg   <= y_high_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            max_iter_reg <= max_iter_next;
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        col_reg     <= col_next;
        row_reg     <= row_next;
        span_reg    <= span_next;
        prod_reg    <= prod_next;
        neg_reg     <= neg_next;
        cre_reg     <= cre_next;
        cim_reg     <= cim_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        xx_reg      <= xx_next;
        sum_reg     <= sum_next;
        diff_reg    <= diff_next;
        n_reg       <= n_next;
        result_reg  <= result_next;
        m_tdata_reg <= m_tdata_next;
    end

    mbe_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_mag[QUO_BITS-1:0]),
        .divisor  (div_dvs),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_reset_drops_result: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_accept_starts_map: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_MULX))
        else $error("transfer did not start the mapping");

    a_div_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIVX || state_reg == ST_DIVY))
        else $error("divider finished outside a wait state");

    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_orbit_starts_at_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIVY && div_done) |=> (x_reg == '0 && y_reg == '0 && n_reg == '0))
        else $error("orbit not cleared before first iteration");

endmodule

// ===== tb/mandelbrot_escape_time_test.sv =====
// Self-checking testbench for the escape-time engine: stream pixels in, check counts out.
module mandelbrot_escape_time_test import mbe_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;
    localparam longint COORD_MAX = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;
    localparam longint unsigned ESCAPE_RADIUS_SQ = 64'd4 << (2 * FRAC_BITS);

    localparam logic [31:0] DEF_X_LEFT  = 32'hE000_0000;
    localparam logic [31:0] DEF_Y_LOW   = 32'hF000_0000;
    localparam logic [31:0] DEF_X_RIGHT = 32'h1000_0000;
    localparam logic [31:0] DEF_Y_HIGH  = 32'h1000_0000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [11:0] pixel_col, [23:12] pixel_row
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [15:0] escape_count
    logic [15:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic [31:0] view_regs [0:6] = '{DEF_X_LEFT, DEF_Y_LOW, DEF_X_RIGHT, DEF_Y_HIGH,
                                     32'd1024, 32'd1024, 32'd255};
    logic [15:0] escape_count_q [$];

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int rx_hold_request = 0;
    int stalled_cycles = 0;
    int mismatches = 0;
    int pixels_sent = 0;
    int counts_checked = 0;
    int register_writes = 0;
    int views_run = 0;

    mandelbrot_escape_time DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 50)
            $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    function automatic longint clamp_q428(input longint v);
        if (v > COORD_MAX)
            return COORD_MAX;
        if (v < COORD_MIN)
            return COORD_MIN;
        return v;
    endfunction

    function automatic longint plane_coord(input longint lo, input longint hi,
                                           input logic [31:0] dim, input logic [11:0] idx);
        longint d;
        longint span_div;
        d = dim;
        if (d > MAX_DIM)
            d = MAX_DIM;
        span_div = (d < 2) ? 1 : d - 1;
        return clamp_q428(lo + (longint'(idx) * (hi - lo)) / span_div);
    endfunction

    function automatic logic [15:0] escape_count_for(input logic [11:0] col,
                                                     input logic [11:0] row);
        longint cre, cim, x, y, nx, ny;
        longint unsigned xx, yy;
        int unsigned n;
        cre = plane_coord(longint'($signed(view_regs[REG_X_LEFT])),
                          longint'($signed(view_regs[REG_X_RIGHT])), view_regs[REG_WIDTH], col);
        cim = plane_coord(longint'($signed(view_regs[REG_Y_LOW])),
                          longint'($signed(view_regs[REG_Y_HIGH])), view_regs[REG_HEIGHT], row);
        x = 0;
        y = 0;
        n = 0;
        forever begin
            xx = x * x;
            yy = y * y;
            if (xx + yy >= ESCAPE_RADIUS_SQ)
                return n[15:0];
            if (n >= view_regs[REG_MAX_ITER])
                return '0;
            nx = (($signed(xx) - $signed(yy)) >>> FRAC_BITS) + cre;
            ny = ((2 * x * y) >>> FRAC_BITS) + cim;
            x = clamp_q428(nx);
            y = clamp_q428(ny);
            n++;
        end
    endfunction

    task automatic apb_transfer(input logic wr, input cfg_reg_t idx,
                                input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
    endtask

    task automatic write_register(input cfg_reg_t idx, input logic [31:0] value);
        logic [31:0] unused;
        apb_transfer(1'b1, idx, value, unused);
        case (idx)
            REG_X_LEFT, REG_Y_LOW, REG_X_RIGHT, REG_Y_HIGH: view_regs[idx] = value;
            REG_WIDTH, REG_HEIGHT: view_regs[idx] = {19'd0, value[12:0]};
            REG_MAX_ITER: view_regs[idx] = {16'd0, value[15:0]};
            default: ;
        endcase
        register_writes++;
    endtask

    task automatic check_registers();
        logic [31:0] readback;
        for (int i = REG_X_LEFT; i <= REG_MAX_ITER; i++) begin
            apb_transfer(1'b0, cfg_reg_t'(i), '0, readback);
            if (readback !== view_regs[i])
                report_mismatch($sformatf("register %0d reads %h, expected %h",
                                          i, readback, view_regs[i]));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_view(input logic [31:0] xl, input logic [31:0] yl,
                            input logic [31:0] xr, input logic [31:0] yh,
                            input logic [31:0] w, input logic [31:0] h,
                            input logic [31:0] iter_limit);
        write_register(REG_X_LEFT, xl);
        write_register(REG_Y_LOW, yl);
        write_register(REG_X_RIGHT, xr);
        write_register(REG_Y_HIGH, yh);
        write_register(REG_WIDTH, w);
        write_register(REG_HEIGHT, h);
        write_register(REG_MAX_ITER, iter_limit);
        check_registers();
        views_run++;
    endtask

    task automatic send_pixel(input logic [11:0] col, input logic [11:0] row);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {row, col};
        do @(posedge aclk); while (!s_tready);
        escape_count_q.push_back(escape_count_for(col, row));
        pixels_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (escape_count_q.size() != 0)
            @(posedge aclk);
    endtask

    task automatic test_reset_view();
        check_registers();
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd682, 12'd512);
        send_pixel(12'd1023, 12'd1023);
        drain_results();
    endtask

    task automatic test_corner_extremes();
        set_view(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'd0, 32'd1, 32'd65535);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd1, 12'd0);
        drain_results();
        write_register(REG_WIDTH, 32'd1);
        write_register(REG_HEIGHT, 32'd0);
        check_registers();
        send_pixel(12'd0, 12'd1);
        send_pixel(12'd4095, 12'd0);
        drain_results();
    endtask

    task automatic test_oversize_and_spare();
        set_view(DEF_X_LEFT, DEF_Y_LOW, DEF_X_RIGHT, DEF_Y_HIGH, 32'd8191, 32'd4097, 32'd0);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd2048, 12'd4095);
        drain_results();
        write_register(REG_MAX_ITER, 32'd40);
        write_register(REG_SPARE, 32'hFFFF_FFFF);
        check_registers();
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd1000, 12'd3000);
        drain_results();
    endtask

    task automatic test_limit_boundary();
        set_view(32'hF000_0000, 32'd0, 32'hF000_0000, 32'd0, 32'd2, 32'd2, 32'd1000);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd1, 12'd1);
        drain_results();
        set_view(DEF_X_LEFT, 32'd0, DEF_X_LEFT, 32'd0, 32'd2, 32'd2, 32'd2);
        send_pixel(12'd0, 12'd0);
        drain_results();
        write_register(REG_MAX_ITER, 32'd1);
        check_registers();
        send_pixel(12'd1, 12'd1);
        drain_results();
        write_register(REG_MAX_ITER, 32'd3);
        check_registers();
        send_pixel(12'd1, 12'd0);
        drain_results();
    endtask

    task automatic test_output_backpressure();
        set_view(DEF_X_LEFT, DEF_Y_LOW, DEF_X_RIGHT, DEF_Y_HIGH, 32'd16, 32'd16, 32'd8);
        rx_hold_request = 3000;
        repeat (6)
            send_pixel(12'($urandom_range(0, 15)), 12'($urandom_range(0, 15)));
        drain_results();
    endtask

    task automatic test_random_views();
        int cx, cy, span;
        int unsigned pick, w, h, iter_limit, col_lim, row_lim;
        logic [31:0] xl, yl, xr, yh;
        logic [11:0] col, row;
        for (int phase = 0; phase < 8; phase++) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                span = 1 << $urandom_range(16, 28);
                cx = int'($urandom_range(0, 671088640)) - 536870912;
                cy = int'($urandom_range(0, 644245094)) - 322122547;
                xl = cx - span;
                xr = cx + span;
                yl = cy - span;
                yh = cy + span;
            end else if (pick < 80) begin
                xl = $urandom();
                xr = $urandom();
                yl = $urandom();
                yh = $urandom();
            end else begin
                xl = DEF_X_LEFT;
                yl = DEF_Y_LOW;
                xr = DEF_X_RIGHT;
                yh = DEF_Y_HIGH;
            end
            pick = $urandom_range(99);
            w = (pick < 70) ? $urandom_range(2, 64) :
                (pick < 90) ? $urandom_range(0, 8191) : $urandom_range(2, 4096);
            pick = $urandom_range(99);
            h = (pick < 70) ? $urandom_range(2, 64) :
                (pick < 90) ? $urandom_range(0, 8191) : $urandom_range(2, 4096);
            pick = $urandom_range(99);
            iter_limit = (pick < 60) ? $urandom_range(1, 32) :
                         (pick < 90) ? $urandom_range(33, 160) : $urandom_range(0, 255);
            set_view(xl, yl, xr, yh, w, h, iter_limit);
            case (phase % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 77; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 77; end
                default: begin tx_idle_pct = 23; rx_stall_pct = 23; end
            endcase
            col_lim = (w < 2) ? 0 : (w > MAX_DIM) ? MAX_DIM - 1 : w - 1;
            row_lim = (h < 2) ? 0 : (h > MAX_DIM) ? MAX_DIM - 1 : h - 1;
            for (int k = 0; k < 66; k++) begin
                col = ($urandom_range(99) < 75) ? 12'($urandom_range(0, col_lim))
                                                : 12'($urandom_range(0, 4095));
                row = ($urandom_range(99) < 75) ? 12'($urandom_range(0, row_lim))
                                                : 12'($urandom_range(0, 4095));
                send_pixel(col, row);
            end
            drain_results();
        end
        tx_idle_pct = 0;
        rx_stall_pct = 0;
    endtask

    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (rx_hold_request > 0) begin
                hold_left = rx_hold_request;
                rx_hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        logic [15:0] expected;
        if (aresetn && m_tvalid && m_tready) begin
            if (escape_count_q.size() == 0) begin
                report_mismatch($sformatf("escape count %0d with no request waiting", m_tdata));
            end else begin
                expected = escape_count_q.pop_front();
                counts_checked++;
                if (m_tdata !== expected)
                    report_mismatch($sformatf("escape_count %0d, expected %0d",
                                              m_tdata, expected));
            end
        end
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable && pready))
            stalled_cycles = 0;
        else
            stalled_cycles++;
    end

    initial begin : watchdog
        while (stalled_cycles < STALL_LIMIT)
            @(posedge aclk);
        $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        aresetn <= 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_view();
        test_corner_extremes();
        test_oversize_and_spare();
        test_limit_boundary();
        test_output_backpressure();
        test_random_views();
        repeat (400) @(posedge aclk);
        $display("Covered %0d pixel requests over %0d views and %0d register writes;",
                 pixels_sent, views_run, register_writes);
        $display("checked %0d escape counts, with idle, stall and long hold-off phases",
                 counts_checked);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
